/* rtl/npcm_pkg.sv */
// Shared types and constants for the nearest palette colour match core.
`default_nettype none
package npcm_pkg;

  // Palette depth and derived slot index width
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Upper key bound used when a query gives zero
  localparam logic [13:0] RANGE_DEFAULT_HIGH = 14'd9999;

  // Redmean weights
  localparam logic [9:0] RED_WEIGHT_BASE  = 10'd512;
  localparam logic [9:0] BLUE_WEIGHT_BASE = 10'd767;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic        operation;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [13:0] key;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [13:0] range_low;
    logic [13:0] range_high;
  } in_t;

  typedef struct packed {
    logic [13:0] match_key;
    logic        found;
    logic        exact;
    logic [19:0] best_distance;
  } out_t;

  // One palette entry as held in the RAM
  typedef struct packed {
    logic [13:0] key;
    color_t      color;
  } entry_t;

  // Candidate handed to the distance unit
  typedef struct packed {
    logic        live;
    logic [13:0] key;
    color_t      query;
    color_t      entry;
  } dist_in_t;

  // Scored candidate leaving the distance unit
  typedef struct packed {
    logic        live;
    logic [13:0] key;
    logic [19:0] distance;
  } dist_out_t;

endpackage
`default_nettype wire

/* rtl/npcm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module npcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/npcm_dist.sv */
// Three-stage redmean weighted squared distance unit.
`default_nettype none
module npcm_dist (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire npcm_pkg::dist_in_t  din,
  output npcm_pkg::dist_out_t      dout
);
  import npcm_pkg::*;

  logic [8:0]  rsum;
  logic [7:0]  dr_abs;
  logic [7:0]  dg_abs;
  logic [7:0]  db_abs;

  logic        s1_live;
  logic [13:0] s1_key;
  logic [7:0]  s1_rm;
  logic [15:0] s1_dr2;
  logic [15:0] s1_dg2;
  logic [15:0] s1_db2;

  logic [9:0]  wr;
  logic [9:0]  wb;
  logic [25:0] pr;
  logic [25:0] pb;

  logic        s2_live;
  logic [13:0] s2_key;
  logic [17:0] s2_tr;
  logic [17:0] s2_tg;
  logic [17:0] s2_tb;

  // Mean red and absolute component differences
  always_comb begin
    rsum   = {1'b0, din.query.red} + {1'b0, din.entry.red};
    dr_abs = (din.query.red >= din.entry.red) ? din.query.red - din.entry.red
                                              : din.entry.red - din.query.red;
    dg_abs = (din.query.green >= din.entry.green) ? din.query.green - din.entry.green
                                                  : din.entry.green - din.query.green;
    db_abs = (din.query.blue >= din.entry.blue) ? din.query.blue - din.entry.blue
                                                : din.entry.blue - din.query.blue;
  end

  // Stage one: square the differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_live <= 1'b0;
    end else begin
      s1_live <= din.live;
    end
    s1_key <= din.key;
    s1_rm  <= rsum[8:1];
    s1_dr2 <= dr_abs * dr_abs;
    s1_dg2 <= dg_abs * dg_abs;
    s1_db2 <= db_abs * db_abs;
  end

  // Red and blue weights from the mean red
  always_comb begin
    wr = RED_WEIGHT_BASE + {2'b00, s1_rm};
    wb = BLUE_WEIGHT_BASE - {2'b00, s1_rm};
    pr = wr * s1_dr2;
    pb = wb * s1_db2;
  end

  // Stage two: weight each term
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_live <= 1'b0;
    end else begin
      s2_live <= s1_live;
    end
    s2_key <= s1_key;
    s2_tr  <= pr[25:8];
    s2_tg  <= {s1_dg2, 2'b00};
    s2_tb  <= pb[25:8];
  end

  // Stage three: sum the terms
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.live <= 1'b0;
    end else begin
      dout.live <= s2_live;
    end
    dout.key      <= s2_key;
    dout.distance <= {2'b00, s2_tr} + {2'b00, s2_tg} + {2'b00, s2_tb};
  end

endmodule
`default_nettype wire

/* rtl/nearest_palette_color_match_core.sv */
// Top level: palette store, scan sequencer and best-match tracking.
//
// Channels: a transaction is taken at a rising edge where start is high and
// busy is low; item carries the operation and its fields. Every transaction
// gives one result on result, marked by done for exactly one cycle.
// Load: writes key and colour into the palette RAM and the slot's valid
// flag; done is registered and rises in the cycle after acceptance, and busy stays low.
// Query: the sequencer walks all ENTRIES slots in order, one RAM read per
// cycle, through one shared three-stage distance unit. A query reads each
// slot in turn, then drains the RAM read and distance pipeline, forms the
// result and presents it. busy is high until done rises; the next
// transaction can be taken at the edge that takes the result.
// The scan of the palette RAM, one slot per cycle, sets the query time.
// Reset clears all valid flags at once, so every slot starts empty;
// keys and colours need no clearing.
// done is not held off: the receiver takes every result as it appears.
`default_nettype none
module nearest_palette_color_match_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire npcm_pkg::in_t  item,
  output logic                busy,
  output logic                done,
  output npcm_pkg::out_t      result
);
  import npcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] scan_idx;
  logic [1:0]       drain_cnt;

  logic             accept;
  logic             load_we;
  logic [IDX_W-1:0] load_addr;
  entry_t           load_entry;
  entry_t           rd_entry;

  logic [ENTRIES-1:0] slot_valid;
  logic               s0_live;

  color_t      q_color;
  logic [13:0] q_low;
  logic [13:0] q_high;

  dist_in_t    din;
  dist_out_t   dout;

  logic        found;
  logic [13:0] best_key;
  logic [19:0] best_d;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign load_we   = accept && (item.operation == OP_LOAD) &&
                     ({1'b0, item.slot} < 7'(ENTRIES));
  assign load_addr = IDX_W'(item.slot);

  assign load_entry.key         = item.key;
  assign load_entry.color.red   = item.red;
  assign load_entry.color.green = item.green;
  assign load_entry.color.blue  = item.blue;

  // Palette keys and colours
  npcm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (load_entry),
    .raddr (scan_idx),
    .rdata (rd_entry)
  );

  // Valid flags, cleared by reset; track the RAM read with s0_live
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      s0_live    <= 1'b0;
    end else begin
      if (load_we) begin
        slot_valid[load_addr] <= item.entry_valid;
      end
      s0_live <= (state == S_SCAN) && slot_valid[scan_idx];
    end
  end

  // Latch the query colour and key range
  always_ff @(posedge clk) begin
    if (accept && (item.operation == OP_QUERY)) begin
      q_color.red   <= item.red;
      q_color.green <= item.green;
      q_color.blue  <= item.blue;
      q_low         <= item.range_low;
      q_high        <= (item.range_high == 14'd0) ? RANGE_DEFAULT_HIGH : item.range_high;
    end
  end

  // Drop slots outside the key range before scoring
  always_comb begin
    din.live  = s0_live && (rd_entry.key >= q_low) && (rd_entry.key <= q_high);
    din.key   = rd_entry.key;
    din.query = q_color;
    din.entry = rd_entry.color;
  end

  npcm_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Keep the first entry with the smallest distance
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept && (item.operation == OP_QUERY)) begin
      found <= 1'b0;
    end else if (dout.live) begin
      found <= 1'b1;
    end
    if (accept && (item.operation == OP_QUERY)) begin
      best_key <= 14'd0;
      best_d   <= 20'd0;
    end else if (dout.live && (!found || (dout.distance < best_d))) begin
      best_key <= dout.key;
      best_d   <= dout.distance;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      drain_cnt <= 2'd0;
      done      <= 1'b0;
      result    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.operation == OP_QUERY) begin
              state    <= S_SCAN;
              scan_idx <= '0;
            end else begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state     <= S_DRAIN;
            drain_cnt <= 2'd0;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == 2'd3) begin
            state <= S_FINISH;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        S_FINISH: begin
          state                <= S_IDLE;
          done                 <= 1'b1;
          result.match_key     <= best_key;
          result.found         <= found;
          result.exact         <= found && (best_d == 20'd0);
          result.best_distance <= best_d;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/nearest_palette_color_match_core_test.sv */
// Self-checking testbench for the nearest palette colour match core.
`default_nettype none
module nearest_palette_color_match_core_test;
  import npcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy;
  logic done;
  out_t result;

  // Testbench copy of the palette
  logic        pal_valid [ENTRIES];
  logic [13:0] pal_key   [ENTRIES];
  color_t      pal_color [ENTRIES];

  out_t pending_matches[$];
  bit   idling_on = 1'b1;
  int   mismatch_count = 0;
  int   stall_cycles = 0;
  int   load_count = 0;
  int   query_count = 0;
  int   found_count = 0;
  int   exact_count = 0;
  int   checked_count = 0;

  nearest_palette_color_match_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Redmean weighted squared distance, compared without the square root
  function automatic logic [19:0] redmean_distance(input color_t a, input color_t b);
    int rm;
    int dr;
    int dg;
    int db;
    int tr;
    int tb;
    rm = (int'(a.red) + int'(b.red)) / 2;
    dr = int'(a.red) - int'(b.red);
    dg = int'(a.green) - int'(b.green);
    db = int'(a.blue) - int'(b.blue);
    tr = ((int'(RED_WEIGHT_BASE) + rm) * dr * dr) >> 8;
    tb = ((int'(BLUE_WEIGHT_BASE) - rm) * db * db) >> 8;
    return 20'(tr + 4 * dg * dg + tb);
  endfunction

  // Work out the result of one transaction and update the palette copy
  function automatic out_t predict_palette_match(input in_t t);
    out_t        r;
    color_t      q;
    logic [13:0] hi;
    logic [19:0] d;
    r = '0;
    if (t.operation == OP_LOAD) begin
      if (int'(t.slot) < ENTRIES) begin
        pal_valid[t.slot] = t.entry_valid;
        pal_key[t.slot]   = t.key;
        pal_color[t.slot] = {t.red, t.green, t.blue};
      end
    end else begin
      hi = (t.range_high == 14'd0) ? RANGE_DEFAULT_HIGH : t.range_high;
      q  = {t.red, t.green, t.blue};
      for (int s = 0; s < ENTRIES; s++) begin
        if (pal_valid[s] && pal_key[s] >= t.range_low && pal_key[s] <= hi) begin
          d = redmean_distance(q, pal_color[s]);
          // keep the first entry on a tie
          if (!r.found || d < r.best_distance) begin
            r.found         = 1'b1;
            r.best_distance = d;
            r.match_key     = pal_key[s];
          end
        end
      end
      r.exact = r.found && (r.best_distance == 20'd0);
    end
    return r;
  endfunction

  // Build a load with random filler in the fields it does not use
  function automatic in_t make_load(input logic [5:0] s, input logic v,
                                    input logic [13:0] k, input color_t c);
    in_t t;
    t.operation   = OP_LOAD;
    t.slot        = s;
    t.entry_valid = v;
    t.key         = k;
    {t.red, t.green, t.blue} = c;
    t.range_low   = 14'($urandom_range(16383, 0));
    t.range_high  = 14'($urandom_range(16383, 0));
    return t;
  endfunction

  // Build a query with random filler in the fields it does not use
  function automatic in_t make_query(input color_t c, input logic [13:0] lo,
                                     input logic [13:0] hi);
    in_t t;
    t.operation   = OP_QUERY;
    t.slot        = 6'($urandom_range(63, 0));
    t.entry_valid = 1'($urandom_range(1, 0));
    t.key         = 14'($urandom_range(16383, 0));
    {t.red, t.green, t.blue} = c;
    t.range_low   = lo;
    t.range_high  = hi;
    return t;
  endfunction

  // Offer one transaction, after a random gap while idling is on, and hold it until taken
  task automatic send_item(input in_t t);
    int   gap;
    out_t want;
    gap = idling_on ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= t;
    do @(posedge clk); while (busy);
    want = predict_palette_match(t);
    pending_matches.push_back(want);
    if (t.operation == OP_LOAD) begin
      load_count++;
    end else begin
      query_count++;
      if (want.found) found_count++;
      if (want.exact) exact_count++;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [19:0] want,
                                 input logic [19:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && done) begin
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, actual %h", $time, result);
      end else begin
        want = pending_matches.pop_front();
        checked_count++;
        if (result.match_key !== want.match_key)
          report_mismatch("match_key", 20'(want.match_key), 20'(result.match_key));
        if (result.found !== want.found)
          report_mismatch("found", 20'(want.found), 20'(result.found));
        if (result.exact !== want.exact)
          report_mismatch("exact", 20'(want.exact), 20'(result.exact));
        if (result.best_distance !== want.best_distance)
          report_mismatch("best_distance", want.best_distance, result.best_distance);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_matches.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Queries against a palette with every slot empty
  task automatic test_empty_palette();
    send_item(make_query(24'h000000, 14'd0, 14'd0));
    send_item(make_query(24'hFFFFFF, 14'd0, 14'd16383));
  endtask

  // Extreme slots, keys and colours, and the largest possible distance
  task automatic test_field_extremes();
    send_item(make_load(6'd0, 1'b1, 14'd0, 24'h000000));
    send_item(make_load(6'd63, 1'b1, 14'd16383, 24'hFFFFFF));
    send_item(make_query(24'h000000, 14'd0, 14'd0));
    send_item(make_query(24'hFFFFFF, 14'd0, 14'd16383));
    send_item(make_query(24'h000000, 14'd16383, 14'd16383));
    send_item(make_query(24'hFFFFFF, 14'd0, 14'd0));
  endtask

  // Bounds of the key range, its default upper bound and empty ranges
  task automatic test_key_range();
    send_item(make_load(6'd1, 1'b1, 14'd9999, 24'hFF00FF));
    send_item(make_load(6'd2, 1'b1, 14'd10000, 24'h00FF00));
    send_item(make_query(24'h00FF00, 14'd0, 14'd0));
    send_item(make_query(24'h00FF00, 14'd10000, 14'd10000));
    send_item(make_query(24'h00FF00, 14'd9999, 14'd9998));
    send_item(make_query(24'h00FF00, 14'd10001, 14'd0));
  endtask

  // Equal colours in two slots, then removal of each in turn
  task automatic test_ties_and_removal();
    send_item(make_load(6'd10, 1'b1, 14'd20, 24'h646464));
    send_item(make_load(6'd11, 1'b1, 14'd21, 24'h646464));
    send_item(make_query(24'h646464, 14'd20, 14'd21));
    send_item(make_query(24'h656464, 14'd20, 14'd21));
    send_item(make_load(6'd10, 1'b0, 14'd20, 24'h646464));
    send_item(make_query(24'h646464, 14'd20, 14'd21));
    send_item(make_load(6'd11, 1'b0, 14'd21, 24'h646464));
    send_item(make_query(24'h646464, 14'd20, 14'd21));
  endtask

  // Random loads and queries with keys and ranges that mostly overlap
  task automatic test_random_traffic(input int count);
    in_t         t;
    color_t      c;
    logic [13:0] k;
    logic [13:0] lo;
    logic [13:0] hi;
    int          load_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idling_on = ($urandom_range(3, 0) != 0);
      // vary the load share so the palette is sparse at times and crowded at others
      case ((n / 150) % 3)
        0: load_pct = 70;
        1: load_pct = 30;
        default: load_pct = 50;
      endcase
      c = 24'($urandom_range(24'hFFFFFF, 0));
      if ($urandom_range(99, 0) < load_pct) begin
        case ($urandom_range(7, 0))
          0: k = 14'($urandom_range(16383, 0));
          1: k = 14'($urandom_range(10010, 9990));
          2: k = 14'($urandom_range(16383, 16370));
          default: k = 14'($urandom_range(63, 0));
        endcase
        t = make_load(6'($urandom_range(63, 0)), ($urandom_range(4, 0) != 0), k, c);
      end else begin
        // aim at a stored colour, or just beside it
        if ($urandom_range(3, 0) == 0) begin
          c = pal_color[$urandom_range(ENTRIES - 1, 0)];
          if ($urandom_range(1, 0) == 1) c.green = c.green + 8'd1;
        end
        case ($urandom_range(5, 0))
          0: begin
            lo = 14'd0;
            hi = 14'd0;
          end
          1: begin
            lo = 14'($urandom_range(63, 0));
            hi = lo + 14'($urandom_range(40, 0));
          end
          2: begin
            lo = 14'd0;
            hi = 14'd16383;
          end
          3: begin
            lo = 14'($urandom_range(16383, 0));
            hi = 14'($urandom_range(16383, 0));
          end
          4: begin
            lo = 14'($urandom_range(10005, 9990));
            hi = ($urandom_range(1, 0) == 1) ? 14'd0 : 14'($urandom_range(10010, 9995));
          end
          default: begin
            lo = 14'($urandom_range(63, 0));
            hi = 14'd0;
          end
        endcase
        t = make_query(c, lo, hi);
      end
      send_item(t);
    end
  endtask

  initial begin
    for (int s = 0; s < ENTRIES; s++) begin
      pal_valid[s] = 1'b0;
      pal_key[s]   = '0;
      pal_color[s] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_palette();
    test_field_extremes();
    test_key_range();
    test_ties_and_removal();
    test_random_traffic(900);
    start <= 1'b0;

    // Drain outstanding results, then allow for stray ones
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d queries, %0d of them found a key, %0d exact.",
             load_count, query_count, found_count, exact_count);
    $display("Compared %0d results field by field.", checked_count);
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
